/* design/lapedge_pkg.sv */
// ----------------------------------------------------------------------------
// lapedge_pkg: shared definitions for the Laplacian edge detector
// Frame limits, field widths, configuration register indexes, item codes and
// the fixed-point gray conversion weights.
// ----------------------------------------------------------------------------
package lapedge_pkg;

  // Largest frame the line stores can hold.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Frame size after reset, before it is clamped to the limits above.
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  // Column and row counters hold 0 .. limit-1.
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Width of one color channel and of one gray sample.
  localparam int PIX_W = 8;

  // Configuration port.
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Item codes on the cmd field.
  localparam logic CMD_DRAIN = 1'b1;

  // Gray weights in units of 1/256.
  localparam int GRAY_R_WT = 77;
  localparam int GRAY_G_WT = 150;
  localparam int GRAY_B_WT = 29;

endpackage

/* design/lapedge_pix_if.sv */
// ----------------------------------------------------------------------------
// lapedge_pix_if: input channel of the edge detector
// Carries one pixel item or one drain tick per transfer.
// ----------------------------------------------------------------------------
interface lapedge_pix_if;

  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [lapedge_pkg::PIX_W-1:0] red;
  logic [lapedge_pkg::PIX_W-1:0] green;
  logic [lapedge_pkg::PIX_W-1:0] blue;

  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink   (input valid, cmd, red, green, blue, output ready);

endinterface

/* design/lapedge_res_if.sv */
// ----------------------------------------------------------------------------
// lapedge_res_if: result channel of the edge detector
// Carries one edge bit and the end-of-frame flag per transfer.
// ----------------------------------------------------------------------------
interface lapedge_res_if;

  logic valid;
  logic ready;
  logic edge_res;
  logic last;

  modport source (output valid, edge_res, last, input ready);
  modport sink   (input valid, edge_res, last, output ready);

endinterface

/* design/laplacian_edge_threshold.sv */
// ----------------------------------------------------------------------------
// laplacian_edge_threshold: 3x3 Laplacian edge detector with threshold
// Gray conversion, two line stores and a 4-neighbor Laplacian on a raster
// stream, giving one binary edge result per pixel.
// ----------------------------------------------------------------------------
// The block takes one transfer and gives one result per clock; each result
// passes the first stage and the output register. Each transfer is either a
// pixel or a drain tick. The result for the pixel at (x, y) is produced by
// the pixel transfer at (x, y + 1); the last row of a frame is produced by drain
// ticks sent after the last pixel, one result per tick, and the final result
// carries last. Pixels sent while drain results are still owed, and drain
// ticks with nothing owed, are taken and dropped. Writing the width or height
// restarts the frame. The rate is set by the two line stores: each is written
// once and read at two addresses per transfer, and a new transfer is taken
// whenever the first pipeline stage is empty or moving on.
// ----------------------------------------------------------------------------
module laplacian_edge_threshold (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lapedge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lapedge_pkg::CFG_DATA_W-1:0]  cfg_data,
  lapedge_pix_if.sink                         pix,
  lapedge_res_if.source                       res
);

  localparam int COL_W  = lapedge_pkg::COL_W;
  localparam int ROW_W  = lapedge_pkg::ROW_W;
  localparam int PIX_W  = lapedge_pkg::PIX_W;
  localparam int GRAY_W = 2 * PIX_W;
  // 4*center minus four neighbors spans -4*255 .. 4*255.
  localparam int LAP_W  = PIX_W + 4;

  localparam int RST_W = (lapedge_pkg::RESET_WIDTH > lapedge_pkg::MAX_WIDTH) ?
                         lapedge_pkg::MAX_WIDTH : lapedge_pkg::RESET_WIDTH;
  localparam int RST_H = (lapedge_pkg::RESET_HEIGHT > lapedge_pkg::MAX_HEIGHT) ?
                         lapedge_pkg::MAX_HEIGHT : lapedge_pkg::RESET_HEIGHT;

  localparam logic [lapedge_pkg::CFG_DATA_W-1:0] CFG_ONE = 1;

  // Side information that travels with a read from the line stores.
  typedef struct packed {
    logic sel;        // parity of the center row: 1 means the odd store
    logic drain;      // bottom row: the lower neighbor is the center
    logic top;        // top row: the upper neighbor is the center
    logic left_edge;  // first column: the left neighbor is the center
    logic last;       // final result of the frame
  } s1_ctrl_t;

  // Configuration, kept as last column and last row after clamping.
  logic [PIX_W-1:0] threshold;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  // Frame position.
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_done;
  logic [COL_W-1:0] drain_col;
  logic             out_done;

  // Line stores: rows of even index go to one, odd rows to the other.
  logic [PIX_W-1:0] line_even [lapedge_pkg::MAX_WIDTH];
  logic [PIX_W-1:0] line_odd  [lapedge_pkg::MAX_WIDTH];
  logic [PIX_W-1:0] even_a, even_b, odd_a, odd_b;

  // First stage and output register.
  logic             s1_valid;
  s1_ctrl_t         s1_ctrl;
  logic [PIX_W-1:0] s1_down;
  logic [PIX_W-1:0] prev_center;
  logic             out_valid;
  logic             out_edge;
  logic             out_last;

  logic             accept;
  logic             is_drain;
  logic             restart;
  logic             pix_take;
  logic             pix_emit;
  logic             drain_emit;
  logic             rd_en;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] rd_addr;
  logic [COL_W-1:0] rd_addr_right;
  logic [GRAY_W-1:0] gray_sum;
  logic [PIX_W-1:0] gray;
  logic             s1_adv;

  logic [PIX_W-1:0] center, up, down, left, right;
  logic signed [LAP_W-1:0] lap;
  logic [PIX_W-1:0] lap_clamped;
  logic             edge_bit;

  // ---------------------------------------------------------------- input side
  assign accept   = pix.valid & pix.ready;
  assign is_drain = (pix.cmd == lapedge_pkg::CMD_DRAIN);

  // Once the whole frame has been sent and all of it delivered, the next pixel
  // opens a new frame at the top left corner.
  assign restart    = in_done & out_done;
  assign pix_take   = accept & ~is_drain & (~in_done | out_done);
  assign drain_emit = accept & is_drain & in_done & ~out_done;
  assign cur_col    = restart ? '0 : in_col;
  assign cur_row    = restart ? '0 : in_row;
  // A pixel of row r completes the neighborhood of the pixel above it.
  assign pix_emit   = pix_take & (cur_row != '0);
  assign rd_en      = pix_take | drain_emit;

  // Both stores are read at the result column and at its right neighbor; the
  // right address is held at the last column, which replicates the border.
  assign rd_addr       = is_drain ? drain_col : cur_col;
  assign rd_addr_right = (rd_addr == w_last) ? rd_addr : rd_addr + COL_W'(1);

  assign gray_sum = GRAY_W'(pix.red)   * GRAY_W'(lapedge_pkg::GRAY_R_WT)
                  + GRAY_W'(pix.green) * GRAY_W'(lapedge_pkg::GRAY_G_WT)
                  + GRAY_W'(pix.blue)  * GRAY_W'(lapedge_pkg::GRAY_B_WT);
  assign gray     = gray_sum[GRAY_W-1:PIX_W];

  // A new transfer is taken whenever the first stage is free or moving on, so
  // a waiting result holds up the input only while the first stage is full.
  assign s1_adv    = s1_valid & (~out_valid | res.ready);
  assign pix.ready = ~s1_valid | s1_adv;

  // ---------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      w_last    <= COL_W'(RST_W - 1);
      h_last    <= ROW_W'(RST_H - 1);
      in_col    <= '0;
      in_row    <= '0;
      in_done   <= 1'b0;
      drain_col <= '0;
      out_done  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lapedge_pkg::REG_THRESHOLD: begin
            threshold <= cfg_data[PIX_W-1:0];
          end
          lapedge_pkg::REG_FRAME_WIDTH: begin
            if (cfg_data == '0) begin
              w_last <= '0;
            end else if (int'(cfg_data) > lapedge_pkg::MAX_WIDTH) begin
              w_last <= COL_W'(lapedge_pkg::MAX_WIDTH - 1);
            end else begin
              w_last <= COL_W'(cfg_data - CFG_ONE);
            end
            in_col  <= '0;
            in_row  <= '0;
            in_done <= 1'b0;
          end
          lapedge_pkg::REG_FRAME_HEIGHT: begin
            if (cfg_data == '0) begin
              h_last <= '0;
            end else if (int'(cfg_data) > lapedge_pkg::MAX_HEIGHT) begin
              h_last <= ROW_W'(lapedge_pkg::MAX_HEIGHT - 1);
            end else begin
              h_last <= ROW_W'(cfg_data - CFG_ONE);
            end
            in_col  <= '0;
            in_row  <= '0;
            in_done <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (pix_take) begin
        if (cur_col == w_last) begin
          in_col <= '0;
          if (cur_row == h_last) begin
            // Frame input complete: the bottom row now waits for drain ticks.
            in_row    <= '0;
            in_done   <= 1'b1;
            drain_col <= '0;
            out_done  <= 1'b0;
          end else begin
            in_row  <= cur_row + ROW_W'(1);
            in_done <= 1'b0;
          end
        end else begin
          in_col  <= cur_col + COL_W'(1);
          in_row  <= cur_row;
          in_done <= 1'b0;
        end
      end

      if (drain_emit) begin
        if (drain_col == w_last) begin
          out_done <= 1'b1;
        end else begin
          drain_col <= drain_col + COL_W'(1);
        end
      end
    end
  end

  // ------------------------------------------------------------ line stores
  // A pixel of row r is written into the store of its parity at its column.
  // The same port reads that address in the same cycle and returns the old
  // entry, which is row r-2: the upper neighbor. The other store holds row
  // r-1 and supplies the center and the right neighbor.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_a <= line_even[rd_addr];
      even_b <= line_even[rd_addr_right];
    end
    if (pix_take & ~cur_row[0]) begin
      line_even[cur_col] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      odd_a <= line_odd[rd_addr];
      odd_b <= line_odd[rd_addr_right];
    end
    if (pix_take & cur_row[0]) begin
      line_odd[cur_col] <= gray;
    end
  end

  // ------------------------------------------------------------ first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= pix_emit | drain_emit;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // On a drain tick the center row is the bottom row; on a pixel it is
      // the row above the incoming pixel.
      s1_ctrl.sel       <= is_drain ? h_last[0] : ~cur_row[0];
      s1_ctrl.drain     <= is_drain;
      s1_ctrl.top       <= is_drain ? (h_last == '0) : (cur_row == ROW_W'(1));
      s1_ctrl.left_edge <= (rd_addr == '0);
      s1_ctrl.last      <= is_drain & (drain_col == w_last);
      s1_down           <= gray;
    end
    // Results leave in raster order, so the center of the previous result is
    // the left neighbor of the next one within a row.
    if (s1_adv) begin
      prev_center <= center;
    end
  end

  always_comb begin
    center = s1_ctrl.sel ? odd_a : even_a;
    right  = s1_ctrl.sel ? odd_b : even_b;
    up     = s1_ctrl.top ? center : (s1_ctrl.sel ? even_a : odd_a);
    down   = s1_ctrl.drain ? center : s1_down;
    left   = s1_ctrl.left_edge ? center : prev_center;
  end

  assign lap = $signed({2'b00, center, 2'b00})
             - $signed({4'b0000, up})
             - $signed({4'b0000, down})
             - $signed({4'b0000, left})
             - $signed({4'b0000, right});

  always_comb begin
    priority if (lap[LAP_W-1]) begin
      lap_clamped = '0;
    end else if (lap[LAP_W-2:PIX_W] != '0) begin
      lap_clamped = '1;
    end else begin
      lap_clamped = lap[PIX_W-1:0];
    end
  end

  assign edge_bit = (lap_clamped > threshold);

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_edge <= edge_bit;
      out_last <= s1_ctrl.last;
    end
  end

  assign res.valid    = out_valid;
  assign res.edge_res = out_edge;
  assign res.last     = out_last;

endmodule
